>>> src/vcs_pkg.sv
// shared types and constants of the velocity command shaper
package vcs_pkg;

   // input command codes
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_VEL    = 3'd1;
   localparam logic [2:0] CMD_STOP   = 3'd2;
   localparam logic [2:0] CMD_ARM    = 3'd3;
   localparam logic [2:0] CMD_DISARM = 3'd4;

   // register indexes
   localparam logic [2:0] REG_PERIOD    = 3'd0;
   localparam logic [2:0] REG_TAU       = 3'd1;
   localparam logic [2:0] REG_LIN_ACCEL = 3'd2;
   localparam logic [2:0] REG_LIN_DECEL = 3'd3;
   localparam logic [2:0] REG_ROT_ACCEL = 3'd4;
   localparam logic [2:0] REG_ROT_DECEL = 3'd5;

   // register reset values
   localparam logic [9:0]  RST_PERIOD    = 10'd50;
   localparam logic [15:0] RST_TAU       = 16'd500;
   localparam logic [15:0] RST_LIN_ACCEL = 16'd1500;
   localparam logic [15:0] RST_LIN_DECEL = 16'd3000;
   localparam logic [15:0] RST_ROT_ACCEL = 16'd4000;
   localparam logic [15:0] RST_ROT_DECEL = 16'd8000;

   // lower bounds and fixed point constants
   localparam logic [9:0]  PERIOD_MIN  = 10'd5;
   localparam logic [16:0] SCALE_ONE   = 17'd65536;
   localparam logic [31:0] MS_RECIP    = 32'd4294967;   // floor(2^32 / 1000)
   localparam logic [31:0] MS_PER_S    = 32'd1000;
   localparam logic [26:0] MS_HALF     = 27'd500;

   // classified operation kinds
   typedef enum logic [2:0] {
      OP_TICK,
      OP_VEL,
      OP_STOP,
      OP_ARM,
      OP_DISARM
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic signed [15:0] adv;
      logic signed [15:0] side;
      logic signed [15:0] rot;
      logic [31:0]        now;
   } op_type;

   typedef struct packed {
      logic [9:0]  period;
      logic [15:0] tau;
      logic [15:0] lin_accel;
      logic [15:0] lin_decel;
      logic [15:0] rot_accel;
      logic [15:0] rot_decel;
   } cfg_type;

endpackage

>>> src/velocity_command_shaper.sv
// Velocity command shaper: a three-axis command with its time stamp, or a stop
// request, is held; each tick taken while armed, or in the stop burst after a
// disarm, decays it by 1/(1+(age/tau)^2) and slew-limits the applied advance, side
// and rotation values toward it. Set-up, arm, disarm and stop transactions are
// taken in the idle state of the back end. An emitting tick runs a freshness
// computation (two squares, a 17 step division, three scalings) unless stopped,
// then three slew steps on one shared multiplier in both cases. A two-entry queue
// takes transactions while the back end works; the back end takes no transaction
// while a result waits to be taken.
module velocity_command_shaper #(
   parameter int STOP_BURST = 5,
   parameter int TIME_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,    // command
   input  logic [79:0] req_tdata,    // target_adv, target_side, target_rot, now_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // out_adv, out_side, out_rot, freshness_scale, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int STAMP_BITS = (TIME_BITS < 32) ? TIME_BITS : 32;

   vcs_pkg::cfg_type   cfg_ff;
   vcs_pkg::op_type    op_data;
   logic               op_valid, op_ready;
   logic signed [15:0] out_adv, out_side, out_rot;
   logic [16:0]        out_scale;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period    <= vcs_pkg::RST_PERIOD;
         cfg_ff.tau       <= vcs_pkg::RST_TAU;
         cfg_ff.lin_accel <= vcs_pkg::RST_LIN_ACCEL;
         cfg_ff.lin_decel <= vcs_pkg::RST_LIN_DECEL;
         cfg_ff.rot_accel <= vcs_pkg::RST_ROT_ACCEL;
         cfg_ff.rot_decel <= vcs_pkg::RST_ROT_DECEL;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            vcs_pkg::REG_PERIOD:    cfg_ff.period    <= csr_pwdata[9:0];
            vcs_pkg::REG_TAU:       cfg_ff.tau       <= csr_pwdata[15:0];
            vcs_pkg::REG_LIN_ACCEL: cfg_ff.lin_accel <= csr_pwdata[15:0];
            vcs_pkg::REG_LIN_DECEL: cfg_ff.lin_decel <= csr_pwdata[15:0];
            vcs_pkg::REG_ROT_ACCEL: cfg_ff.rot_accel <= csr_pwdata[15:0];
            vcs_pkg::REG_ROT_DECEL: cfg_ff.rot_decel <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[4:2])
         vcs_pkg::REG_PERIOD:    csr_prdata = {22'd0, cfg_ff.period};
         vcs_pkg::REG_TAU:       csr_prdata = {16'd0, cfg_ff.tau};
         vcs_pkg::REG_LIN_ACCEL: csr_prdata = {16'd0, cfg_ff.lin_accel};
         vcs_pkg::REG_LIN_DECEL: csr_prdata = {16'd0, cfg_ff.lin_decel};
         vcs_pkg::REG_ROT_ACCEL: csr_prdata = {16'd0, cfg_ff.rot_accel};
         vcs_pkg::REG_ROT_DECEL: csr_prdata = {16'd0, cfg_ff.rot_decel};
         default:                csr_prdata = 32'd0;
      endcase
   end

   vcs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op_data    (op_data)
   );

   vcs_back #(
      .STOP_BURST (STOP_BURST),
      .STAMP_BITS (STAMP_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op_data   (op_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_adv   (out_adv),
      .out_side  (out_side),
      .out_rot   (out_rot),
      .out_scale (out_scale)
   );

   assign rsp_tdata = {7'd0, out_scale, out_rot, out_side, out_adv};

`ifndef SYNTHESIS
   // freshness factor never exceeds one
   a_scale_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[64:48] <= 17'd65536))
      else $error("freshness scale above one");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // tick period register takes the written data
   a_period_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[4:2] == vcs_pkg::REG_PERIOD) |=>
         (cfg_ff.period == $past(csr_pwdata[9:0])))
      else $error("tick period write lost");
`endif

endmodule

>>> src/vcs_front.sv
// front end: accepts transactions, classifies the command and queues operations
module vcs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          req_tuser,
   input  logic [79:0]         req_tdata,
   output logic                op_valid,
   input  logic                op_ready,
   output vcs_pkg::op_type     op_data
);

   vcs_pkg::op_type queue_ff [2];
   vcs_pkg::op_type entry;
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            known;
   logic            push, pop;

   // classify the command code
   always_comb begin
      known      = 1'b1;
      entry.kind = vcs_pkg::OP_TICK;
      unique case (req_tuser)
         vcs_pkg::CMD_TICK:   entry.kind = vcs_pkg::OP_TICK;
         vcs_pkg::CMD_VEL:    entry.kind = vcs_pkg::OP_VEL;
         vcs_pkg::CMD_STOP:   entry.kind = vcs_pkg::OP_STOP;
         vcs_pkg::CMD_ARM:    entry.kind = vcs_pkg::OP_ARM;
         vcs_pkg::CMD_DISARM: entry.kind = vcs_pkg::OP_DISARM;
         default:             known      = 1'b0;
      endcase
      entry.adv  = req_tdata[15:0];
      entry.side = req_tdata[31:16];
      entry.rot  = req_tdata[47:32];
      entry.now  = req_tdata[79:48];
   end

   assign req_tready = (count_ff != 2'd2);
   assign op_valid   = (count_ff != 2'd0);
   assign op_data    = queue_ff[rd_ptr_ff];

   // unknown codes are dropped here
   assign push = req_tvalid && req_tready && known;
   assign pop  = op_valid && op_ready;

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

>>> src/vcs_back.sv
// back end: holds the command state and runs freshness, scaling and slew limiting
module vcs_back #(
   parameter int STOP_BURST = 5,
   parameter int STAMP_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  vcs_pkg::cfg_type   cfg,
   input  logic               op_valid,
   output logic               op_ready,
   input  vcs_pkg::op_type    op_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [15:0] out_adv,
   output logic signed [15:0] out_side,
   output logic signed [15:0] out_rot,
   output logic [16:0]        out_scale
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TT, ST_AA, ST_DINIT, ST_DIV, ST_PMUL, ST_PCAP,
      ST_RMUL, ST_X, ST_XM, ST_QM, ST_CORR, ST_APPLY
   } state_type;

   state_type          state_ff;
   logic signed [15:0] applied_ff [3];
   logic signed [15:0] pending_ff [3];
   logic signed [15:0] tgt_ff [3];
   logic [STAMP_BITS-1:0] stamp_ff;
   logic [STAMP_BITS-1:0] now_ff;
   logic               stop_ff, armed_ff;
   logic [2:0]         burst_ff;
   logic [31:0]        age_ff;
   logic [63:0]        prod_ff;
   logic [31:0]        t2_ff;
   logic [64:0]        den_ff;
   logic [65:0]        rem_ff;
   logic [16:0]        quo_ff;
   logic [4:0]         bit_ff;
   logic [16:0]        scale_ff;
   logic [1:0]         axis_ff;
   logic [26:0]        x_ff;
   logic [16:0]        q0_ff;
   logic [16:0]        lim_ff;
   logic               out_valid_ff;
   logic signed [15:0] out_adv_ff, out_side_ff, out_rot_ff;
   logic [16:0]        out_scale_ff;

   logic [31:0]        mul_a, mul_b;
   logic [STAMP_BITS-1:0] now_m;
   logic [9:0]         period;
   logic [15:0]        tau;
   logic signed [15:0] pend_sel, cur_sel, tgt_sel;
   logic [16:0]        pmag, cmag, tmag;
   logic [15:0]        rate_acc, rate_dec, rate_sel;
   logic [65:0]        rem_shift, den_shift;
   logic               div_take;
   logic [16:0]        quo_next;
   logic [16:0]        sc_round;
   logic [26:0]        rem_ms;
   logic signed [17:0] diff, lim_s, step;
   logic signed [16:0] new_app;

   assign op_ready  = (state_ff == ST_IDLE) && !out_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_adv   = out_adv_ff;
   assign out_side  = out_side_ff;
   assign out_rot   = out_rot_ff;
   assign out_scale = out_scale_ff;

   // clamped configuration and masked time
   always_comb begin
      period = (cfg.period < vcs_pkg::PERIOD_MIN) ? vcs_pkg::PERIOD_MIN : cfg.period;
      tau    = (cfg.tau == 16'd0) ? 16'd1 : cfg.tau;
      now_m  = op_data.now[STAMP_BITS-1:0];
   end

   // per axis selection and magnitudes
   always_comb begin
      pend_sel = pending_ff[axis_ff];
      cur_sel  = applied_ff[axis_ff];
      tgt_sel  = tgt_ff[axis_ff];
      pmag     = pend_sel[15] ? 17'(-{pend_sel[15], pend_sel}) : {1'b0, pend_sel};
      cmag     = cur_sel[15] ? 17'(-{cur_sel[15], cur_sel}) : {1'b0, cur_sel};
      tmag     = tgt_sel[15] ? 17'(-{tgt_sel[15], tgt_sel}) : {1'b0, tgt_sel};
      rate_acc = (axis_ff == 2'd2) ? cfg.rot_accel : cfg.lin_accel;
      rate_dec = (axis_ff == 2'd2) ? cfg.rot_decel : cfg.lin_decel;
      rate_sel = (tmag >= cmag) ? rate_acc : rate_dec;
   end

   // shared multiplier operands
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         ST_TT: begin
            mul_a = {16'd0, tau};
            mul_b = {16'd0, tau};
         end
         ST_AA: begin
            mul_a = age_ff;
            mul_b = age_ff;
         end
         ST_PMUL: begin
            mul_a = {15'd0, pmag};
            mul_b = {15'd0, scale_ff};
         end
         ST_RMUL: begin
            mul_a = {16'd0, rate_sel};
            mul_b = {22'd0, period};
         end
         ST_XM: begin
            mul_a = {5'd0, x_ff};
            mul_b = vcs_pkg::MS_RECIP;
         end
         ST_QM: begin
            mul_a = prod_ff[63:32];
            mul_b = vcs_pkg::MS_PER_S;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   // one restoring division step, quotient bit per cycle
   always_comb begin
      rem_shift = rem_ff >> bit_ff;
      den_shift = {1'b0, den_ff} << bit_ff;
      div_take  = rem_shift >= {1'b0, den_ff};
      quo_next  = quo_ff;
      quo_next[bit_ff[3:0] == 4'd0 && bit_ff[4] ? 16 : bit_ff[3:0]] = div_take;
   end

   // rounding of scaled target, ms remainder and clamped step
   always_comb begin
      sc_round = 17'((prod_ff[33:0] + 34'd32768) >> 16);
      rem_ms   = x_ff - prod_ff[26:0];
      diff     = 18'(tgt_sel) - 18'(cur_sel);
      lim_s    = {1'b0, lim_ff};
      if (diff > lim_s) begin
         step = lim_s;
      end else if (diff < -lim_s) begin
         step = -lim_s;
      end else begin
         step = diff;
      end
      new_app = 17'(cur_sel) + 17'(step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < 3; i++) begin
            applied_ff[i] <= '0;
            pending_ff[i] <= '0;
         end
         stamp_ff     <= '0;
         stop_ff      <= 1'b1;
         armed_ff     <= 1'b0;
         burst_ff     <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_TT || state_ff == ST_AA || state_ff == ST_PMUL ||
             state_ff == ST_RMUL || state_ff == ST_XM || state_ff == ST_QM) begin
            prod_ff <= mul_a * mul_b;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (op_valid && op_ready) begin
                  unique case (op_data.kind)
                     vcs_pkg::OP_VEL: begin
                        pending_ff[0] <= op_data.adv;
                        pending_ff[1] <= op_data.side;
                        pending_ff[2] <= op_data.rot;
                        stamp_ff      <= now_m;
                        stop_ff       <= 1'b0;
                     end
                     vcs_pkg::OP_STOP: begin
                        for (int i = 0; i < 3; i++) begin
                           pending_ff[i] <= '0;
                        end
                        stamp_ff <= now_m;
                        stop_ff  <= 1'b1;
                     end
                     vcs_pkg::OP_ARM: begin
                        armed_ff <= 1'b1;
                     end
                     vcs_pkg::OP_DISARM: begin
                        if (armed_ff) begin
                           armed_ff <= 1'b0;
                           stop_ff  <= 1'b1;
                           burst_ff <= 3'(STOP_BURST);
                           for (int i = 0; i < 3; i++) begin
                              applied_ff[i] <= '0;
                           end
                        end
                     end
                     vcs_pkg::OP_TICK: begin
                        if (armed_ff || burst_ff != 3'd0) begin
                           if (!armed_ff) begin
                              burst_ff <= burst_ff - 3'd1;
                           end
                           now_ff  <= now_m;
                           axis_ff <= 2'd0;
                           if (stop_ff) begin
                              scale_ff <= vcs_pkg::SCALE_ONE;
                              for (int i = 0; i < 3; i++) begin
                                 tgt_ff[i] <= '0;
                              end
                              state_ff <= ST_RMUL;
                           end else begin
                              state_ff <= ST_TT;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_TT: begin
               age_ff   <= (now_ff > stamp_ff) ? 32'(now_ff - stamp_ff) : 32'd0;
               state_ff <= ST_AA;
            end
            ST_AA: begin
               t2_ff    <= prod_ff[31:0];
               state_ff <= ST_DINIT;
            end
            ST_DINIT: begin
               den_ff   <= 65'(t2_ff) + 65'(prod_ff);
               rem_ff   <= 66'({t2_ff, 16'd0}) + 66'((65'(t2_ff) + 65'(prod_ff)) >> 1);
               quo_ff   <= 17'd0;
               bit_ff   <= 5'd16;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               quo_ff <= quo_next;
               if (div_take) begin
                  rem_ff <= rem_ff - den_shift;
               end
               if (bit_ff == 5'd0) begin
                  scale_ff <= quo_next;
                  axis_ff  <= 2'd0;
                  state_ff <= ST_PMUL;
               end else begin
                  bit_ff <= bit_ff - 5'd1;
               end
            end
            ST_PMUL: begin
               state_ff <= ST_PCAP;
            end
            ST_PCAP: begin
               tgt_ff[axis_ff] <= pend_sel[15] ? 16'(-sc_round) : sc_round[15:0];
               if (axis_ff == 2'd2) begin
                  axis_ff  <= 2'd0;
                  state_ff <= ST_RMUL;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= ST_PMUL;
               end
            end
            ST_RMUL: begin
               state_ff <= ST_X;
            end
            ST_X: begin
               x_ff     <= prod_ff[26:0] + vcs_pkg::MS_HALF;
               state_ff <= ST_XM;
            end
            ST_XM: begin
               state_ff <= ST_QM;
            end
            ST_QM: begin
               q0_ff    <= prod_ff[48:32];
               state_ff <= ST_CORR;
            end
            ST_CORR: begin
               lim_ff   <= (rem_ms >= 27'(vcs_pkg::MS_PER_S)) ? q0_ff + 17'd1 : q0_ff;
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               applied_ff[axis_ff] <= new_app[15:0];
               if (axis_ff == 2'd2) begin
                  out_adv_ff   <= applied_ff[0];
                  out_side_ff  <= applied_ff[1];
                  out_rot_ff   <= new_app[15:0];
                  out_scale_ff <= scale_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= ST_RMUL;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
